// ===== src/arpc_pkg.sv =====
// Shared types and constants of the address-resolution cache with aging.
package arpc_pkg;

  localparam logic ACT_LOOKUP = 1'b0;
  localparam logic ACT_INSERT = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd60;

  typedef struct packed {
    logic        action;
    logic [31:0] ip_address;
    logic [47:0] mac_address;
    logic [31:0] now_seconds;
  } arpc_req_t;

  typedef struct packed {
    logic        hit;
    logic [47:0] found_mac;
    logic [3:0]  slot_index;
  } arpc_resp_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } arpc_entry_t;

endpackage

// ===== src/arp_cache_with_aging.sv =====
// Top level of the address-resolution cache with aging and oldest-entry eviction.
//
// An item (lookup or insert, with the current time in seconds) is taken on a
// rising edge where start is high and busy is low. busy stays high while the
// item is scanned. The single result appears on result, marked by done for
// exactly one cycle; the receiver cannot stall and must take it then.
// The entry memory is read one entry per cycle through its registered read
// port, and an insert adds a write-back step after the scan. A lookup hit
// ends early at the matching entry, and an insert ends its scan at the first
// entry it may reuse.
// A new item may be started in the cycle its predecessor's result is shown.
// The timeout register is written through cfg_we and cfg_wdata; the user must
// write it only while idle, which the block itself does not enforce.
// Reset clears all valid bits and the fill count and sets the timeout to 60
// seconds; entry contents need no clearing pass since only filled entries
// are ever read.
module arp_cache_with_aging #(
  parameter int ENTRIES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  arpc_pkg::arpc_req_t  request,
  output logic                 done,
  output arpc_pkg::arpc_resp_t result,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_wdata
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  logic [15:0]           timeout;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  arpc_pkg::arpc_entry_t mem_wdata;
  logic [AW-1:0]         mem_raddr;
  arpc_pkg::arpc_entry_t mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= arpc_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout <= cfg_wdata;
    end
  end

  arpc_table #(
    .ENTRIES(ENTRIES),
    .AW     (AW)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  arpc_ctrl #(
    .ENTRIES(ENTRIES),
    .AW     (AW),
    .CW     (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .timeout  (timeout),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

`ifndef ASSERT_OFF
  // Every item that finishes delivers its result as busy drops.
  a_done_at_finish: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy fell without a result");

  // A result is shown only once the sequencer has returned to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // No item completes in the cycle right after it is accepted.
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result appeared one cycle after accept");
`endif

endmodule

// ===== src/arpc_table.sv =====
// Entry memory of the cache: one write port and one registered read port.
module arpc_table #(
  parameter int ENTRIES = 16,
  parameter int AW      = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  arpc_pkg::arpc_entry_t wdata,
  input  logic [AW-1:0]         raddr,
  output arpc_pkg::arpc_entry_t rdata
);

  arpc_pkg::arpc_entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/arpc_ctrl.sv =====
// Scan sequencer of the cache: valid bits, fill count, lookup and insert decisions.
module arpc_ctrl #(
  parameter int ENTRIES = 16,
  parameter int AW      = 4,
  parameter int CW      = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  arpc_pkg::arpc_req_t   request,
  input  logic [15:0]           timeout,
  output logic                  busy,
  output logic                  done,
  output arpc_pkg::arpc_resp_t  result,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output arpc_pkg::arpc_entry_t mem_wdata,
  output logic [AW-1:0]         mem_raddr,
  input  arpc_pkg::arpc_entry_t mem_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_t;

  state_t              state;
  arpc_pkg::arpc_req_t req;
  logic [CW-1:0]       rd_idx;
  logic                ev_vld;
  logic [AW-1:0]       ev_idx;
  logic                ev_last;
  logic [CW-1:0]       used_count;
  logic [ENTRIES-1:0]  valid;
  logic [AW-1:0]       evict_idx;
  logic [31:0]         oldest_stamp;
  logic [AW-1:0]       slot;

  logic          issue;
  logic          ev_valid;
  logic          ip_match;
  logic [31:0]   age;
  logic          stale;
  logic          older;
  logic          scan_end;
  logic          is_insert;
  logic [AW+3:0] ev_ext;
  logic [AW+3:0] slot_ext;

  assign issue     = (state == S_SCAN) && (rd_idx < used_count);
  assign ev_valid  = valid[ev_idx];
  assign ip_match  = (mem_rdata.ip == req.ip_address);
  assign age       = req.now_seconds - mem_rdata.stamp;
  assign stale     = age > {16'b0, timeout};
  assign older     = (ev_idx == '0) || (mem_rdata.stamp < oldest_stamp);
  assign scan_end  = ev_vld ? ev_last : (used_count == '0);
  assign is_insert = (req.action == arpc_pkg::ACT_INSERT);
  assign ev_ext    = {4'b0, ev_idx};
  assign slot_ext  = {4'b0, slot};

  assign busy      = (state != S_IDLE);
  assign mem_raddr = rd_idx[AW-1:0];
  assign mem_we    = (state == S_WRITE);
  assign mem_waddr = slot;
  assign mem_wdata = '{ip: req.ip_address, mac: req.mac_address, stamp: req.now_seconds};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      done       <= 1'b0;
      used_count <= '0;
      valid      <= '0;
      ev_vld     <= 1'b0;
    end else begin
      done    <= 1'b0;
      ev_vld  <= issue;
      ev_idx  <= rd_idx[AW-1:0];
      ev_last <= ((rd_idx + CW'(1)) == used_count);
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req    <= request;
            rd_idx <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ev_vld && is_insert && (ip_match || !ev_valid)) begin
            slot   <= ev_idx;
            ev_vld <= 1'b0;
            state  <= S_WRITE;
          end else if (ev_vld && !is_insert && ev_valid && ip_match && !stale) begin
            done   <= 1'b1;
            result <= '{hit: 1'b1, found_mac: mem_rdata.mac, slot_index: ev_ext[3:0]};
            ev_vld <= 1'b0;
            state  <= S_IDLE;
          end else begin
            if (ev_vld && !is_insert && ev_valid && ip_match) begin
              valid[ev_idx] <= 1'b0;
            end
            if (ev_vld && is_insert && older) begin
              evict_idx    <= ev_idx;
              oldest_stamp <= mem_rdata.stamp;
            end
            if (scan_end) begin
              ev_vld <= 1'b0;
              if (!is_insert) begin
                done   <= 1'b1;
                result <= '0;
                state  <= S_IDLE;
              end else if (used_count < CW'(ENTRIES)) begin
                slot       <= used_count[AW-1:0];
                used_count <= used_count + CW'(1);
                state      <= S_WRITE;
              end else begin
                slot  <= (ev_vld && older) ? ev_idx : evict_idx;
                state <= S_WRITE;
              end
            end
          end
        end
        S_WRITE: begin
          valid[slot] <= 1'b1;
          done        <= 1'b1;
          result      <= '{hit: 1'b1, found_mac: 48'b0, slot_index: slot_ext[3:0]};
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
